// ----- design/dras_pkg.sv -----
// ----------------------------------------------------------------------------
// dras_pkg
// shared types and codes of the delayed reuse slot allocator
// ----------------------------------------------------------------------------
package dras_pkg;

   localparam logic [1:0] CMD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_FREE  = 2'd1;
   localparam logic [1:0] CMD_LOAD  = 2'd2;

   localparam logic [1:0] MARK_USED = 2'd0;
   localparam logic [1:0] MARK_FREE = 2'd1;
   localparam logic [1:0] MARK_TAIL = 2'd2;

   localparam logic [31:0] REUSE_DELAY = 32'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_GRANT,
      ST_FREE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic        valid;
      logic        ok;
      logic        dec;
      logic        load;
      logic [7:0]  granted;
      logic [15:0] load_value;
   } done_type;

endpackage

// ----- design/delayed_reuse_slot_allocator_top.sv -----
// ----------------------------------------------------------------------------
// delayed_reuse_slot_allocator_top
// slot allocator with a free tail mark and a two-frame reuse delay
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy stays high
// until the request is finished. An allocate scans the slot memory from slot
// 0 upward, one slot a cycle through its registered read port, and stops
// at the first slot that qualifies or after the last slot. Free and load
// keep busy high for one cycle. The response shows on the rsp_ ports for
// one cycle, marked by rsp_valid, in the cycle after the request completes;
// there is no way to hold it off, and the next request may be issued in
// that same cycle. After reset the block writes every slot once, with busy
// high, before it takes its first request.
// ----------------------------------------------------------------------------
module delayed_reuse_slot_allocator_top #(
   parameter int NUM_SLOTS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_frame_now,
   input  logic [7:0]  req_slot_index,
   input  logic [15:0] req_load_value,
   output logic        rsp_valid,
   output logic        rsp_ok,
   output logic [7:0]  rsp_granted_slot,
   output logic [15:0] rsp_pending_count
);

   localparam int IDX_W = $clog2(NUM_SLOTS);

   logic [IDX_W-1:0]   rd_addr;
   logic [IDX_W-1:0]   wr_addr;
   logic               mark_we;
   logic [1:0]         wr_mark;
   logic               stamp_we;
   logic [31:0]        wr_stamp;
   logic [1:0]         rd_mark;
   logic [31:0]        rd_stamp;
   dras_pkg::done_type done;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_ok_ff, rsp_ok_in;
   logic [7:0]  rsp_granted_ff, rsp_granted_in;
   logic [15:0] pending_ff, pending_in;

   dras_ctrl #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_cmd        (req_cmd),
      .req_frame_now  (req_frame_now),
      .req_slot_index (req_slot_index),
      .req_load_value (req_load_value),
      .busy           (busy),
      .rd_addr        (rd_addr),
      .wr_addr        (wr_addr),
      .mark_we        (mark_we),
      .wr_mark        (wr_mark),
      .stamp_we       (stamp_we),
      .wr_stamp       (wr_stamp),
      .rd_mark        (rd_mark),
      .rd_stamp       (rd_stamp),
      .done           (done)
   );

   dras_slot_store #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_store (
      .clock    (clock),
      .rd_addr  (rd_addr),
      .wr_addr  (wr_addr),
      .mark_we  (mark_we),
      .wr_mark  (wr_mark),
      .stamp_we (stamp_we),
      .wr_stamp (wr_stamp),
      .rd_mark  (rd_mark),
      .rd_stamp (rd_stamp)
   );

   always_comb begin
      rsp_valid_in   = done.valid;
      rsp_ok_in      = rsp_ok_ff;
      rsp_granted_in = rsp_granted_ff;
      pending_in     = pending_ff;
      if (done.valid) begin
         rsp_ok_in      = done.ok;
         rsp_granted_in = done.granted;
         if (done.load) begin
            pending_in = done.load_value;
         end else if (done.dec && (pending_ff != '0)) begin
            pending_in = pending_ff - 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pending_ff   <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pending_ff   <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ok_ff      <= rsp_ok_in;
      rsp_granted_ff <= rsp_granted_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ok            = rsp_ok_ff;
   assign rsp_granted_slot  = rsp_granted_ff;
   assign rsp_pending_count = pending_ff;

endmodule

// ----- design/dras_slot_store.sv -----
// ----------------------------------------------------------------------------
// dras_slot_store
// slot mark and reuse stamp memories, one write port each, registered read
// ----------------------------------------------------------------------------
module dras_slot_store #(
   parameter int NUM_SLOTS = 256
) (
   input  logic                         clock,
   input  logic [$clog2(NUM_SLOTS)-1:0] rd_addr,
   input  logic [$clog2(NUM_SLOTS)-1:0] wr_addr,
   input  logic                         mark_we,
   input  logic [1:0]                   wr_mark,
   input  logic                         stamp_we,
   input  logic [31:0]                  wr_stamp,
   output logic [1:0]                   rd_mark,
   output logic [31:0]                  rd_stamp
);

   logic [1:0]  mark_mem  [NUM_SLOTS];
   logic [31:0] stamp_mem [NUM_SLOTS];
   logic [1:0]  rd_mark_ff;
   logic [31:0] rd_stamp_ff;

   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem[wr_addr] <= wr_mark;
      end
      if (stamp_we) begin
         stamp_mem[wr_addr] <= wr_stamp;
      end
      rd_mark_ff  <= mark_mem[rd_addr];
      rd_stamp_ff <= stamp_mem[rd_addr];
   end

   assign rd_mark  = rd_mark_ff;
   assign rd_stamp = rd_stamp_ff;

endmodule

// ----- design/dras_ctrl.sv -----
// ----------------------------------------------------------------------------
// dras_ctrl
// command sequencer: clearing pass, slot scan with the shared reuse compare,
// grant with tail move, free and load
// ----------------------------------------------------------------------------
module dras_ctrl #(
   parameter int NUM_SLOTS = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [1:0]                   req_cmd,
   input  logic [31:0]                  req_frame_now,
   input  logic [7:0]                   req_slot_index,
   input  logic [15:0]                  req_load_value,
   output logic                         busy,
   output logic [$clog2(NUM_SLOTS)-1:0] rd_addr,
   output logic [$clog2(NUM_SLOTS)-1:0] wr_addr,
   output logic                         mark_we,
   output logic [1:0]                   wr_mark,
   output logic                         stamp_we,
   output logic [31:0]                  wr_stamp,
   input  logic [1:0]                   rd_mark,
   input  logic [31:0]                  rd_stamp,
   output dras_pkg::done_type           done
);

   localparam int IDX_W = $clog2(NUM_SLOTS);
   localparam int CNT_W = $clog2(NUM_SLOTS + 1);
   localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(NUM_SLOTS - 1);

   dras_pkg::state_type state_ff, state_in;

   logic [1:0]       cmd_ff, cmd_in;
   logic [31:0]      frame_ff, frame_in;
   logic [7:0]       idx_ff, idx_in;
   logic [15:0]      load_ff, load_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic [IDX_W-1:0] chk_ff, chk_in;
   logic             chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0] hit_ff, hit_in;
   logic             tail_ff, tail_in;
   logic [IDX_W-1:0] clr_ff, clr_in;

   logic             accept;
   logic             qualifies;
   logic             hit;
   logic             miss;
   logic [CMP_W-1:0] idx_ext;
   logic             in_range;
   logic [CMP_W-1:0] hit_ext;

   assign accept    = start && (state_ff == dras_pkg::ST_IDLE);
   assign qualifies = ((rd_mark == dras_pkg::MARK_FREE) || (rd_mark == dras_pkg::MARK_TAIL))
                      && (frame_ff >= rd_stamp);
   assign hit       = chk_vld_ff && qualifies;
   assign miss      = chk_vld_ff && !qualifies && (chk_ff == LAST_SLOT);
   assign idx_ext   = CMP_W'(idx_ff);
   assign in_range  = idx_ext < CMP_W'(NUM_SLOTS);
   assign hit_ext   = CMP_W'(hit_ff);
   assign busy      = (state_ff != dras_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dras_pkg::ST_CLEAR: begin
            if (clr_ff == LAST_SLOT) begin
               state_in = dras_pkg::ST_IDLE;
            end
         end
         dras_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  dras_pkg::CMD_ALLOC: state_in = dras_pkg::ST_SCAN;
                  dras_pkg::CMD_FREE:  state_in = dras_pkg::ST_FREE;
                  default:             state_in = dras_pkg::ST_FINISH;
               endcase
            end
         end
         dras_pkg::ST_SCAN: begin
            if (hit) begin
               state_in = dras_pkg::ST_GRANT;
            end else if (miss) begin
               state_in = dras_pkg::ST_IDLE;
            end
         end
         dras_pkg::ST_GRANT:  state_in = dras_pkg::ST_IDLE;
         dras_pkg::ST_FREE:   state_in = dras_pkg::ST_IDLE;
         dras_pkg::ST_FINISH: state_in = dras_pkg::ST_IDLE;
         default:             state_in = dras_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd_in     = cmd_ff;
      frame_in   = frame_ff;
      idx_in     = idx_ff;
      load_in    = load_ff;
      scan_in    = scan_ff;
      chk_in     = chk_ff;
      chk_vld_in = 1'b0;
      hit_in     = hit_ff;
      tail_in    = tail_ff;
      clr_in     = clr_ff;
      rd_addr    = scan_ff[IDX_W-1:0];
      wr_addr    = clr_ff;
      mark_we    = 1'b0;
      wr_mark    = dras_pkg::MARK_USED;
      stamp_we   = 1'b0;
      wr_stamp   = '0;
      done       = '0;
      case (state_ff)
         dras_pkg::ST_CLEAR: begin
            mark_we  = 1'b1;
            stamp_we = 1'b1;
            wr_mark  = (clr_ff == '0) ? dras_pkg::MARK_TAIL : dras_pkg::MARK_USED;
            clr_in   = clr_ff + IDX_W'(1);
         end
         dras_pkg::ST_IDLE: begin
            if (accept) begin
               cmd_in   = req_cmd;
               frame_in = req_frame_now;
               idx_in   = req_slot_index;
               load_in  = req_load_value;
               scan_in  = '0;
            end
         end
         dras_pkg::ST_SCAN: begin
            if (scan_ff != CNT_W'(NUM_SLOTS)) begin
               chk_vld_in = 1'b1;
               chk_in     = scan_ff[IDX_W-1:0];
               scan_in    = scan_ff + CNT_W'(1);
            end
            if (hit) begin
               chk_vld_in = 1'b0;
               mark_we    = 1'b1;
               wr_addr    = chk_ff;
               wr_mark    = dras_pkg::MARK_USED;
               hit_in     = chk_ff;
               tail_in    = (rd_mark == dras_pkg::MARK_TAIL) && (chk_ff != LAST_SLOT);
            end else if (miss) begin
               chk_vld_in = 1'b0;
               done.valid = 1'b1;
            end
         end
         dras_pkg::ST_GRANT: begin
            mark_we      = tail_ff;
            wr_addr      = hit_ff + IDX_W'(1);
            wr_mark      = dras_pkg::MARK_TAIL;
            done.valid   = 1'b1;
            done.ok      = 1'b1;
            done.dec     = 1'b1;
            done.granted = hit_ext[7:0];
         end
         dras_pkg::ST_FREE: begin
            mark_we    = in_range;
            stamp_we   = in_range;
            wr_addr    = idx_ext[IDX_W-1:0];
            wr_mark    = dras_pkg::MARK_FREE;
            wr_stamp   = frame_ff + dras_pkg::REUSE_DELAY;
            done.valid = 1'b1;
            done.ok    = in_range;
         end
         dras_pkg::ST_FINISH: begin
            done.valid      = 1'b1;
            done.ok         = (cmd_ff == dras_pkg::CMD_LOAD);
            done.load       = (cmd_ff == dras_pkg::CMD_LOAD);
            done.load_value = load_ff;
         end
         default: begin
            done = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= dras_pkg::ST_CLEAR;
         clr_ff     <= '0;
         chk_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         chk_vld_ff <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      frame_ff <= frame_in;
      idx_ff   <= idx_in;
      load_ff  <= load_in;
      scan_ff  <= scan_in;
      chk_ff   <= chk_in;
      hit_ff   <= hit_in;
      tail_ff  <= tail_in;
   end

endmodule

// ----- design/dras_checker.sv -----
// ----------------------------------------------------------------------------
// dras_checker
// port-level checks of the slot allocator request and response timing
// ----------------------------------------------------------------------------
module dras_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_ok,
   input logic [7:0]  rsp_granted_slot
);

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without a request in progress");

   a_accept_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after a request");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_fail_no_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_granted_slot == 8'd0))
      else $error("slot reported on a failed request");

endmodule

bind delayed_reuse_slot_allocator_top dras_checker u_dras_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_ok           (rsp_ok),
   .rsp_granted_slot (rsp_granted_slot)
);
